### sv/ssp_pkg.sv
// Shared types, codes and constants for the servo status packet parser.
// Used by ssp_front, ssp_back and the top level; depends on nothing else.
package ssp_pkg;

   // Default receive window in bytes after a start beat.
   localparam int RX_WINDOW_DEFAULT = 32;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 1;

   // Frame constants.
   localparam logic [7:0] HDR_BYTE  = 8'hFF;
   localparam logic [7:0] ANY_ID    = 8'hFE;
   localparam logic [7:0] NO_ERROR  = 8'h00;
   localparam logic [7:0] MIN_LEN   = 8'd2;
   localparam int         MIN_REPLY = 6;

   // Request type codes carried on req_tuser.
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   // Result kind codes carried on rsp_tuser.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TIMEOUT  = 3'd1,
      ST_NOHDR    = 3'd2,
      ST_SERVO    = 3'd3,
      ST_CHECKSUM = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_FF1  = 3'd1,
      PH_FF2  = 3'd2,
      PH_ID   = 3'd3,
      PH_LEN  = 3'd4,
      PH_ERR  = 3'd5,
      PH_DATA = 3'd6,
      PH_CHK  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_CLOSE = 2'd2
   } cmd_kind_type;

   // One classified command handed from the front to the back.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   rx_byte;
      logic [7:0]   target_id;
      logic [7:0]   request_length;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic       out_kind;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      status_type status;
      logic       last;
   } result_type;

endpackage

### sv/ssp_front.sv
// Front part of the parser: accepts request beats, classifies them and queues them.
// Depends on ssp_pkg.
module ssp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ssp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [ssp_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                         cmd_valid,
   output ssp_pkg::cmd_type             cmd,
   input  logic                         cmd_ready
);
   import ssp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   cmd_type            new_cmd;
   logic               keep;
   logic               push;
   logic               pop;

   // Classify the beat; unknown request types are dropped here.
   always_comb begin
      new_cmd.rx_byte        = req_tdata[7:0];
      new_cmd.target_id      = req_tdata[15:8];
      new_cmd.request_length = req_tdata[23:16];
      new_cmd.kind           = CMD_START;
      keep                   = 1'b1;
      unique case (req_tuser)
         REQ_START: new_cmd.kind = CMD_START;
         REQ_BYTE:  new_cmd.kind = CMD_BYTE;
         REQ_CLOSE: new_cmd.kind = CMD_CLOSE;
         default:   keep = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### sv/ssp_back.sv
// Back part of the parser: frame state machine, running checksum and result register.
// Depends on ssp_pkg.
module ssp_back #(
   parameter int RX_WINDOW = ssp_pkg::RX_WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  ssp_pkg::cmd_type    cmd,
   output logic                cmd_ready,
   output logic                rsp_valid,
   output ssp_pkg::result_type rsp,
   input  logic                rsp_ready
);
   import ssp_pkg::*;

   localparam int WIN_W = $clog2(RX_WINDOW + 1);

   phase_type          phase_ff, phase_in;
   logic [WIN_W-1:0]   window_count_ff, window_count_in;
   logic [7:0]         running_sum_ff, running_sum_in;
   logic [7:0]         frame_length_ff, frame_length_in;
   logic [7:0]         data_count_ff, data_count_in;
   logic [7:0]         expected_id_ff, expected_id_in;
   logic [7:0]         wanted_length_ff, wanted_length_in;
   logic               header_seen_ff, header_seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               step;
   logic               take;
   logic [7:0]         b;
   logic [7:0]         data_count_inc;
   logic               id_match;
   logic               res_valid;
   result_type         res;

   assign cmd_ready      = !rsp_valid_ff || rsp_ready;
   assign step           = cmd_valid && cmd_ready;
   assign b              = cmd.rx_byte;
   // A received byte is parsed only while armed and inside the window.
   assign take           = (cmd.kind == CMD_BYTE) && (phase_ff != PH_IDLE) &&
                           (window_count_ff < WIN_W'(RX_WINDOW));
   assign data_count_inc = data_count_ff + 8'd1;
   assign id_match       = (b == expected_id_ff) || (expected_id_ff == ANY_ID);

   // Next state of the frame machine and its datapath.
   always_comb begin
      phase_in         = phase_ff;
      window_count_in  = window_count_ff;
      running_sum_in   = running_sum_ff;
      frame_length_in  = frame_length_ff;
      data_count_in    = data_count_ff;
      expected_id_in   = expected_id_ff;
      wanted_length_in = wanted_length_ff;
      header_seen_in   = header_seen_ff;
      if (step) begin
         case (cmd.kind)
            CMD_START: begin
               expected_id_in   = cmd.target_id;
               wanted_length_in = cmd.request_length;
               phase_in         = PH_FF1;
               window_count_in  = '0;
               running_sum_in   = '0;
               frame_length_in  = '0;
               data_count_in    = '0;
               header_seen_in   = 1'b0;
            end
            CMD_BYTE: begin
               if (take) begin
                  window_count_in = window_count_ff + 1'b1;
                  unique case (phase_ff)
                     PH_FF1: begin
                        if (b == HDR_BYTE) phase_in = PH_FF2;
                     end
                     PH_FF2: begin
                        phase_in = (b == HDR_BYTE) ? PH_ID : PH_FF1;
                     end
                     PH_ID: begin
                        if (id_match) begin
                           header_seen_in = 1'b1;
                           running_sum_in = b;
                           phase_in       = PH_LEN;
                        end else if (b != HDR_BYTE) begin
                           phase_in = PH_FF1;
                        end
                     end
                     PH_LEN: begin
                        if (b < MIN_LEN) begin
                           phase_in = PH_IDLE;
                        end else begin
                           frame_length_in = b;
                           running_sum_in  = running_sum_ff + b;
                           phase_in        = PH_ERR;
                        end
                     end
                     PH_ERR: begin
                        if (b != NO_ERROR) begin
                           phase_in = PH_IDLE;
                        end else begin
                           running_sum_in = running_sum_ff + b;
                           data_count_in  = '0;
                           phase_in = (frame_length_ff == MIN_LEN) ? PH_CHK : PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        running_sum_in = running_sum_ff + b;
                        data_count_in  = data_count_inc;
                        if (data_count_inc >= (frame_length_ff - MIN_LEN)) phase_in = PH_CHK;
                     end
                     PH_CHK: begin
                        phase_in = PH_IDLE;
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
            CMD_CLOSE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result produced by the command in hand.
   always_comb begin
      res_valid      = 1'b0;
      res.out_kind   = KIND_STATUS;
      res.data_byte  = '0;
      res.data_index = '0;
      res.status     = ST_OK;
      res.last       = 1'b1;
      if (cmd.kind == CMD_CLOSE && phase_ff != PH_IDLE) begin
         res_valid  = 1'b1;
         res.status = ((window_count_ff < WIN_W'(MIN_REPLY)) || header_seen_ff) ?
                      ST_TIMEOUT : ST_NOHDR;
      end else if (take) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (b < MIN_LEN) begin
                  res_valid  = 1'b1;
                  res.status = ST_CHECKSUM;
               end
            end
            PH_ERR: begin
               if (b != NO_ERROR) begin
                  res_valid  = 1'b1;
                  res.status = ST_SERVO;
               end
            end
            PH_DATA: begin
               if (data_count_ff < wanted_length_ff) begin
                  res_valid      = 1'b1;
                  res.out_kind   = KIND_DATA;
                  res.data_byte  = b;
                  res.data_index = data_count_ff;
                  res.last       = 1'b0;
               end
            end
            PH_CHK: begin
               res_valid  = 1'b1;
               res.status = (~running_sum_ff == b) ? ST_OK : ST_CHECKSUM;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Output register: refilled whenever it is empty or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd_ready) begin
         rsp_valid_in = step && res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         window_count_ff  <= '0;
         running_sum_ff   <= '0;
         frame_length_ff  <= '0;
         data_count_ff    <= '0;
         expected_id_ff   <= '0;
         wanted_length_ff <= '0;
         header_seen_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         window_count_ff  <= window_count_in;
         running_sum_ff   <= running_sum_in;
         frame_length_ff  <= frame_length_in;
         data_count_ff    <= data_count_in;
         expected_id_ff   <= expected_id_in;
         wanted_length_ff <= wanted_length_in;
         header_seen_ff   <= header_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### sv/servo_status_packet_parser_unit.sv
// Top level of the servo status packet parser: front queue, back parser, result packing.
// Depends on ssp_pkg, ssp_front and ssp_back.
//
//   Channel | Direction | Payload
//   req     | in        | tuser[1:0] req_type; tdata rx_byte, target_id, request_length
//   rsp     | out       | tuser out_kind; tdata data_byte, data_index, status; tlast last
//
// One beat per cycle sustained while the rsp side does not stall; the frame machine
// updates its whole state on each accepted command, and an accepted request beat is
// registered in the two-entry command queue, then its result in the result register.
// Synchronous active-high reset empties the queue, idles the parser and drops rsp_tvalid.
// A stalled rsp side fills the queue, after which req_tready falls.
module servo_status_packet_parser_unit #(
   parameter int RX_WINDOW = ssp_pkg::RX_WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rx_byte [7:0], target_id [15:8], request_length [23:16]
   input  logic [ssp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type [1:0]
   input  logic [ssp_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // data_byte [7:0], data_index [15:8], status [18:16], zero fill [23:19]
   output logic [ssp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // out_kind [0]
   output logic [ssp_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);
   import ssp_pkg::*;

   logic       cmd_valid;
   logic       cmd_ready;
   cmd_type    cmd;
   result_type rsp;

   ssp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   ssp_back #(
      .RX_WINDOW (RX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .rsp_ready (rsp_tready)
   );

   // Pack the result beat onto the stream ports.
   assign rsp_tdata = {(RSP_TDATA_W - 19)'(0), rsp.status, rsp.data_index, rsp.data_byte};
   assign rsp_tuser = rsp.out_kind;
   assign rsp_tlast = rsp.last;

endmodule

### sv/ssp_checker.sv
// Port-level checks on the result stream of the servo status packet parser.
// Depends on the top level's ports only; bound to servo_status_packet_parser_unit below.
module ssp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Reset leaves no result beat pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // A data beat never ends the transaction and carries a zero status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 1'b0) |-> !rsp_tlast && (rsp_tdata[23:16] == 8'd0))
      else $error("data beat with status or last set");

   // A status beat ends the transaction, has empty data fields and a known code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 1'b1) |-> rsp_tlast && (rsp_tdata[15:0] == 16'd0) &&
                                            (rsp_tdata[23:16] <= 8'd4))
      else $error("malformed status beat");

endmodule

bind servo_status_packet_parser_unit ssp_checker u_checker (.*);

### tb/servo_status_packet_parser_unit_tb.sv
// Self-checking testbench for servo_status_packet_parser_unit: directed table, then random replies.
// Depends on ssp_pkg and the parser RTL; results are checked by an in-bench predictor or the table.
`timescale 1ns / 1ps

module servo_status_packet_parser_unit_tb;
   import ssp_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PHASE_BEATS   = 320;
   localparam int TIMEOUT_NS    = 4_000_000;

   // How a row is checked: by the predictor, by a result typed into the table, or none awaited.
   typedef enum logic [1:0] {
      CHECK_PREDICT,
      CHECK_NONE,
      CHECK_STATUS
   } check_mode_type;

   typedef struct {
      logic [1:0]     kind;
      logic [7:0]     rx;
      logic [7:0]     sid;
      logic [7:0]     rlen;
      check_mode_type check;
      status_type     status;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   // Checking mode that travels with the request beat.
   check_mode_type beat_check = CHECK_PREDICT;
   status_type     beat_status = ST_OK;

   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int mismatch_count = 0;

   result_type     awaited_results [$];
   stim_row_type   directed_rows [$];

   // Predicted parser state.
   phase_type  parse_phase = PH_IDLE;
   logic [5:0] win_count = '0;
   logic [7:0] frame_sum = '0;
   logic [7:0] frame_len = '0;
   logic [7:0] data_seen = '0;
   logic [7:0] armed_id = '0;
   logic [7:0] wanted_len = '0;
   logic       hdr_found = 1'b0;

   servo_status_packet_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Ends the transaction with a final status beat.
   function automatic result_type end_status(input status_type st);
      result_type res;
      res = '0;
      res.out_kind = KIND_STATUS;
      res.status = st;
      res.last = 1'b1;
      parse_phase = PH_IDLE;
      return res;
   endfunction

   // Advances the predicted parser by one request beat; returns 1 when a result follows.
   function automatic bit parse_reply_beat(input logic [1:0] kind, input logic [7:0] rx,
                                           input logic [7:0] sid, input logic [7:0] rlen,
                                           output result_type res);
      bit hit;
      hit = 1'b0;
      res = '0;
      case (kind)
         REQ_START: begin
            armed_id = sid;
            wanted_len = rlen;
            parse_phase = PH_FF1;
            win_count = '0;
            frame_sum = '0;
            frame_len = '0;
            data_seen = '0;
            hdr_found = 1'b0;
         end
         REQ_BYTE: begin
            if (parse_phase != PH_IDLE && win_count < RX_WINDOW_DEFAULT) begin
               win_count = win_count + 1'b1;
               case (parse_phase)
                  PH_FF1: begin
                     if (rx == HDR_BYTE) parse_phase = PH_FF2;
                  end
                  PH_FF2: begin
                     parse_phase = (rx == HDR_BYTE) ? PH_ID : PH_FF1;
                  end
                  PH_ID: begin
                     if (rx == armed_id || armed_id == ANY_ID) begin
                        hdr_found = 1'b1;
                        frame_sum = rx;
                        parse_phase = PH_LEN;
                     end else if (rx != HDR_BYTE) begin
                        parse_phase = PH_FF1;
                     end
                  end
                  PH_LEN: begin
                     if (rx < MIN_LEN) begin
                        hit = 1'b1;
                        res = end_status(ST_CHECKSUM);
                     end else begin
                        frame_len = rx;
                        frame_sum = frame_sum + rx;
                        parse_phase = PH_ERR;
                     end
                  end
                  PH_ERR: begin
                     if (rx != NO_ERROR) begin
                        hit = 1'b1;
                        res = end_status(ST_SERVO);
                     end else begin
                        frame_sum = frame_sum + rx;
                        data_seen = '0;
                        parse_phase = (frame_len == MIN_LEN) ? PH_CHK : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     frame_sum = frame_sum + rx;
                     if (data_seen < wanted_len) begin
                        hit = 1'b1;
                        res.out_kind = KIND_DATA;
                        res.data_byte = rx;
                        res.data_index = data_seen;
                     end
                     data_seen = data_seen + 1'b1;
                     if (data_seen >= frame_len - MIN_LEN) parse_phase = PH_CHK;
                  end
                  PH_CHK: begin
                     hit = 1'b1;
                     res = end_status((~frame_sum == rx) ? ST_OK : ST_CHECKSUM);
                  end
                  default: ;
               endcase
            end
         end
         REQ_CLOSE: begin
            if (parse_phase != PH_IDLE) begin
               hit = 1'b1;
               res = end_status((win_count < MIN_REPLY || hdr_found) ? ST_TIMEOUT : ST_NOHDR);
            end
         end
         default: ;
      endcase
      return hit;
   endfunction

   task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
      if (expv !== actv) begin
         $error("%s: expected %0h, actual %0h", name, expv, actv);
         mismatch_count++;
      end
   endtask

   // Both handshakes are sampled at the edge, so values are the ones settled before it.
   always @(posedge clock) begin : watch_beats
      result_type predicted;
      result_type wanted;
      bit         produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result beat with nothing expected: tuser %0h tdata %0h last %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               wanted = awaited_results.pop_front();
               check_field("out_kind", 8'(wanted.out_kind), 8'(rsp_tuser[0]));
               check_field("data_byte", wanted.data_byte, rsp_tdata[7:0]);
               check_field("data_index", wanted.data_index, rsp_tdata[15:8]);
               check_field("status", 8'(wanted.status), 8'(rsp_tdata[18:16]));
               check_field("last", 8'(wanted.last), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            produced = parse_reply_beat(req_tuser, req_tdata[7:0], req_tdata[15:8],
                                        req_tdata[23:16], predicted);
            case (beat_check)
               CHECK_PREDICT: begin
                  if (produced) awaited_results.push_back(predicted);
               end
               CHECK_STATUS: begin
                  awaited_results.push_back('{out_kind: KIND_STATUS, data_byte: 8'h00,
                                              data_index: 8'h00, status: beat_status,
                                              last: 1'b1});
               end
               default: ;
            endcase
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one request beat and waits until it is accepted.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] rx, input logic [7:0] sid,
                            input logic [7:0] rlen, input check_mode_type check = CHECK_PREDICT,
                            input status_type st = ST_OK);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {rlen, sid, rx};
      beat_check <= check;
      beat_status <= st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed replies with random content; some noise, junk and broken frames.
   task automatic send_reply_sequence(output int beats);
      logic [7:0] frame_bytes [$];
      logic [7:0] sid, rlen, id, len, err, chk, sum, d;
      int         shape;
      bit         truncated;
      beats = 0;
      truncated = 1'b0;
      shape = $urandom_range(99);
      if (shape < 8) begin
         send_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255, 1)));
         beats = 1;
         return;
      end
      sid = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) sid = ANY_ID;
      if ($urandom_range(3) == 0) rlen = 8'($urandom_range(255, 1));
      else rlen = 8'($urandom_range(4, 1));
      send_beat(REQ_START, 8'($urandom_range(255)), sid, rlen);
      beats++;

      // A window with no header at all.
      if (shape < 14) begin
         repeat ($urandom_range(10, 4)) begin
            send_beat(REQ_BYTE, 8'($urandom_range(250)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            beats++;
         end
         send_beat(REQ_CLOSE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
         beats++;
         return;
      end

      repeat (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0)
         frame_bytes.push_back(8'($urandom_range(255)));
      frame_bytes.push_back(HDR_BYTE);
      frame_bytes.push_back(HDR_BYTE);
      if ($urandom_range(4) == 0) frame_bytes.push_back(HDR_BYTE);
      id = sid;
      if (sid == ANY_ID || $urandom_range(7) == 0) id = 8'($urandom_range(255));
      case ($urandom_range(9))
         0: len = 8'($urandom_range(1));
         1: len = 8'($urandom_range(40, 9));
         default: len = 8'($urandom_range(8, 2));
      endcase
      err = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : NO_ERROR;
      sum = id + len + err;
      frame_bytes.push_back(id);
      frame_bytes.push_back(len);
      frame_bytes.push_back(err);
      for (int i = 2; i < len; i++) begin
         d = 8'($urandom_range(255));
         sum = sum + d;
         frame_bytes.push_back(d);
      end
      chk = ~sum;
      if ($urandom_range(7) == 0) chk = chk ^ 8'($urandom_range(255, 1));
      frame_bytes.push_back(chk);

      // Cut the frame short now and then.
      if ($urandom_range(7) == 0) begin
         truncated = 1'b1;
         repeat ($urandom_range(frame_bytes.size() - 1, 1)) d = frame_bytes.pop_back();
      end
      foreach (frame_bytes[i]) begin
         send_beat(REQ_BYTE, frame_bytes[i], 8'($urandom_range(255)), 8'($urandom_range(255)));
         beats++;
      end
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(3, 1)) begin
            send_beat(REQ_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
            beats++;
         end
      end
      if (truncated || $urandom_range(2) == 0) begin
         send_beat(REQ_CLOSE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
         beats++;
      end
   endtask

   initial begin : stimulus
      int sent;
      int n;

      // Idle cases, short length after a run of header bytes, servo error, zero request
      // length, forwarding cut at the wanted length, start while busy, early close.
      directed_rows.push_back('{REQ_CLOSE, 8'h00, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_START, 8'hFF, 8'h01, 8'hFF, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h01, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h01, 8'h00, 8'h00, CHECK_STATUS, ST_CHECKSUM});
      directed_rows.push_back('{REQ_START, 8'h00, ANY_ID, 8'h01, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'hFF, 8'hFF, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'hFF, 8'hFF, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h00, 8'hFF, 8'hFF, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h02, 8'hFF, 8'hFF, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h80, 8'hFF, 8'hFF, CHECK_STATUS, ST_SERVO});
      directed_rows.push_back('{REQ_START, 8'h00, 8'h10, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h10, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h03, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h00, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hAA, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h42, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_START, 8'h55, 8'h01, 8'h01, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h01, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h04, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h00, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'h00, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFB, 8'h00, 8'h00, CHECK_PREDICT, ST_OK});
      directed_rows.push_back('{REQ_START, 8'h00, 8'h00, 8'h04, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_BYTE, 8'hFF, 8'h00, 8'h00, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_START, 8'h00, 8'hFF, 8'h02, CHECK_NONE, ST_OK});
      directed_rows.push_back('{REQ_CLOSE, 8'h00, 8'h00, 8'h00, CHECK_STATUS, ST_TIMEOUT});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].kind, directed_rows[i].rx, directed_rows[i].sid,
                   directed_rows[i].rlen, directed_rows[i].check, directed_rows[i].status);
      wait_for_results();

      // Random replies under four idle patterns, draining between them.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         sent = 0;
         while (sent < PHASE_BEATS) begin
            send_reply_sequence(n);
            sent += n;
         end
         wait_for_results();
      end

      // Long receiver hold-off while the sender keeps pushing, so the input backs up.
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b1;
      sent = 0;
      while (sent < 100) begin
         send_reply_sequence(n);
         sent += n;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DRAIN_LIMIT && awaited_results.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
